### hw/rtl/vertex_scale_rotate_translate_assert.svh
// Assertion macros for the vertex transform block
`ifndef VERTEX_SCALE_ROTATE_TRANSLATE_ASSERT_SVH
`define VERTEX_SCALE_ROTATE_TRANSLATE_ASSERT_SVH
// consequent holds in the same cycle
`define VSRT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("vsrt assertion failed");
// consequent holds in the next cycle
`define VSRT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("vsrt assertion failed");
`endif

### hw/rtl/vsrt_pkg.sv
// Package: constants, types and helpers for the vertex transform block
`default_nettype none
package vsrt_pkg;
  localparam int CordicSteps = 16;
  localparam int AngW        = 16;
  localparam int ZW          = 20;
  localparam int CsW         = 19;
  localparam int CoordW      = 21;
  localparam int ScW         = 33;
  localparam int ProdW       = 52;
  localparam logic signed [AngW-1:0] AngPi     = 16'sd25736;
  localparam logic signed [AngW-1:0] AngHalfPi = 16'sd12868;
  localparam logic signed [CsW-1:0]  GainInv   = 19'sd39797;
  localparam logic signed [CoordW-1:0] OutMax = 21'sd1048575;
  localparam logic signed [CoordW-1:0] OutMin = -21'sd1048576;

  typedef struct packed {
    logic signed [CsW-1:0] x;
    logic signed [CsW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  neg;
    logic signed [ScW-1:0] sx;
    logic signed [ScW-1:0] sy;
    logic signed [CoordW-1:0] ox;
    logic signed [CoordW-1:0] oy;
  } cell_t;

  function automatic logic signed [ZW-1:0] atan_f(input logic [3:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        4'd0: r = 20'sd51472;  4'd1: r = 20'sd30385;  4'd2: r = 20'sd16055;
        4'd3: r = 20'sd8150;   4'd4: r = 20'sd4091;   4'd5: r = 20'sd2047;
        4'd6: r = 20'sd1024;   4'd7: r = 20'sd512;    4'd8: r = 20'sd256;
        4'd9: r = 20'sd128;    4'd10: r = 20'sd64;    4'd11: r = 20'sd32;
        4'd12: r = 20'sd16;    4'd13: r = 20'sd8;     4'd14: r = 20'sd4;
        default: r = 20'sd2;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### hw/rtl/vsrt_cell.sv
// One CORDIC rotation cell; carries the item's payload to the next cell
`default_nettype none
module vsrt_cell
  import vsrt_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_vld,
  input  wire cell_t in_d,
  output logic       out_vld,
  output cell_t      out_d
);
  localparam logic [3:0] IdxC = 4'(Idx);
  logic  vld_r;
  cell_t d_r, d_nxt;
  logic signed [CsW-1:0] dx, dy;

  always_comb begin
    dx = in_d.y >>> Idx;
    dy = in_d.x >>> Idx;
    d_nxt = in_d;
    if (!in_d.z[ZW-1]) begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - atan_f(IdxC);
    end else begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + atan_f(IdxC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= in_vld;
    d_r <= d_nxt;
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
endmodule
`default_nettype wire

### hw/rtl/vertex_scale_rotate_translate.sv
// Top level: scale, CORDIC rotate and translate of one 2D vertex per request
// Usage:
//  Raise start with a request on the in_ ports; busy is always low, so a
//  request is taken at every clock edge with start high, one per cycle.
//  Stage 0 clamps and folds the angle and forms the scaled vertex.
//  Sixteen CORDIC cells follow, one rotation step each, chained so that
//  every cell hands its item to the next cell each cycle.
//  Two product stages form the rotation, a final stage rounds, adds the
//  offset and saturates.
//  Throughput: one request per cycle, set by the cell chain, which holds
//  one request per cell.
//  out_valid is high for one cycle with out_x, out_y and out_saturated;
//  the receiver cannot stall and need not, since nothing is held back.
//  Synchronous reset drops every valid bit; requests in flight are lost.
`default_nettype none
module vertex_scale_rotate_translate
  import vsrt_pkg::*;
#(
  parameter int unsigned Steps = CordicSteps
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire signed [15:0]       in_vertex_x,
  input  wire signed [15:0]       in_vertex_y,
  input  wire [15:0]              in_scale_factor,
  input  wire signed [15:0]       in_angle,
  input  wire signed [20:0]       in_offset_x,
  input  wire signed [20:0]       in_offset_y,
  output logic                    out_valid,
  output logic signed [20:0]      out_x,
  output logic signed [20:0]      out_y,
  output logic                    out_saturated
);
  logic  v0_r;
  cell_t c0_r, c0_nxt;
  logic  vc [Steps+1];
  cell_t dc [Steps+1];
  logic signed [AngW-1:0] a_cl, a_rd;
  logic neg;

  assign busy = 1'b0;

  always_comb begin
    a_cl = in_angle;
    if (in_angle > AngPi) a_cl = AngPi;
    if (in_angle < -AngPi) a_cl = -AngPi;
    neg = 1'b0;
    a_rd = a_cl;
    if (a_cl > AngHalfPi) begin
      a_rd = a_cl - AngPi;
      neg = 1'b1;
    end else if (a_cl < -AngHalfPi) begin
      a_rd = a_cl + AngPi;
      neg = 1'b1;
    end
    c0_nxt.x   = GainInv;
    c0_nxt.y   = '0;
    c0_nxt.z   = ZW'(signed'(a_rd)) <<< 3;
    c0_nxt.neg = neg;
    c0_nxt.sx  = ScW'(signed'(in_vertex_x)) * signed'({1'b0, in_scale_factor});
    c0_nxt.sy  = ScW'(signed'(in_vertex_y)) * signed'({1'b0, in_scale_factor});
    c0_nxt.ox  = in_offset_x;
    c0_nxt.oy  = in_offset_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start & ~busy;
    c0_r <= c0_nxt;
  end

  assign vc[0] = v0_r;
  assign dc[0] = c0_r;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    vsrt_cell #(.Idx(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .in_vld(vc[g]), .in_d(dc[g]),
      .out_vld(vc[g+1]), .out_d(dc[g+1])
    );
  end

  // product, rotation-sum and output stages
  logic v1_r, v2_r, vo_r;
  logic signed [ProdW-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [ProdW-1:0] rx_r, ry_r;
  logic signed [CoordW-1:0] o1x_r, o1y_r, o2x_r, o2y_r;
  logic signed [CsW-1:0] cs, sn;
  logic signed [ProdW-1:0] qx, qy;
  logic signed [ProdW-1:0] tx, ty;
  logic sx_hi, sx_lo, sy_hi, sy_lo;
  logic signed [CoordW-1:0] x_nxt, y_nxt;

  always_comb begin
    cs = dc[Steps].neg ? -dc[Steps].x : dc[Steps].x;
    sn = dc[Steps].neg ? -dc[Steps].y : dc[Steps].y;
  end

  always_comb begin
    qx = (rx_r + (ProdW'(1) <<< 23)) >>> 24;
    qy = (ry_r + (ProdW'(1) <<< 23)) >>> 24;
    tx = qx + ProdW'(o2x_r);
    ty = qy + ProdW'(o2y_r);
    sx_hi = tx > ProdW'(OutMax);
    sx_lo = tx < ProdW'(OutMin);
    sy_hi = ty > ProdW'(OutMax);
    sy_lo = ty < ProdW'(OutMin);
    x_nxt = sx_hi ? OutMax : (sx_lo ? OutMin : tx[CoordW-1:0]);
    y_nxt = sy_hi ? OutMax : (sy_lo ? OutMin : ty[CoordW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= vc[Steps];
      v2_r <= v1_r;
      vo_r <= v2_r;
    end
    p_xc_r <= ProdW'(dc[Steps].sx) * ProdW'(cs);
    p_ys_r <= ProdW'(dc[Steps].sy) * ProdW'(sn);
    p_xs_r <= ProdW'(dc[Steps].sx) * ProdW'(sn);
    p_yc_r <= ProdW'(dc[Steps].sy) * ProdW'(cs);
    o1x_r  <= dc[Steps].ox;
    o1y_r  <= dc[Steps].oy;
    rx_r   <= p_xc_r - p_ys_r;
    ry_r   <= p_xs_r + p_yc_r;
    o2x_r  <= o1x_r;
    o2y_r  <= o1y_r;
    out_x  <= x_nxt;
    out_y  <= y_nxt;
    out_saturated <= sx_hi | sx_lo | sy_hi | sy_lo;
  end

  assign out_valid = vo_r;

`include "vertex_scale_rotate_translate_assert.svh"
  `VSRT_ASSERT_NOW(a_never_busy, clk, rst_n, 1'b1, !busy)
  `VSRT_ASSERT_NEXT(a_chain_in, clk, rst_n, start, vc[0])
  `VSRT_ASSERT_NEXT(a_out_from_chain, clk, rst_n, v2_r, out_valid)
endmodule
`default_nettype wire

### dv/testbench.sv
// Testbench for the vertex scale, rotate and translate block: directed table, then random
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import vsrt_pkg::*;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [15:0]        sc;
    logic signed [15:0] ang;
    logic signed [20:0] ox;
    logic signed [20:0] oy;
  } vtx_req_t;

  typedef struct {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic               sat;
  } vtx_res_t;

  typedef struct {
    vtx_req_t req;
    bit       known;
    vtx_res_t res;
  } vtx_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_vertex_x = '0;
  logic signed [15:0] in_vertex_y = '0;
  logic [15:0] in_scale_factor = '0;
  logic signed [15:0] in_angle = '0;
  logic signed [20:0] in_offset_x = '0;
  logic signed [20:0] in_offset_y = '0;
  logic out_valid;
  logic signed [20:0] out_x;
  logic signed [20:0] out_y;
  logic out_saturated;

  vtx_res_t expected_q[$];
  int mismatches = 0;

  vertex_scale_rotate_translate u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_vertex_x(in_vertex_x), .in_vertex_y(in_vertex_y),
    .in_scale_factor(in_scale_factor), .in_angle(in_angle),
    .in_offset_x(in_offset_x), .in_offset_y(in_offset_y),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
    .out_saturated(out_saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_place(longint q32, longint off, ref bit sat);
    longint v;
    v = floor_sh(q32 + (longint'(1) << 23), 24) + off;
    if (v > 1048575) begin
      sat = 1'b1;
      return 1048575;
    end
    if (v < -1048576) begin
      sat = 1'b1;
      return -1048576;
    end
    return v;
  endfunction

  function automatic vtx_res_t transform_vertex(vtx_req_t r);
    longint atans[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
    longint a, cx, cy, z, dx, dy, sx, sy;
    bit flip, sat;
    vtx_res_t o;
    a = r.ang;
    flip = 1'b0;
    sat = 1'b0;
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    if (a > 12868) begin
      a -= 25736;
      flip = 1'b1;
    end else if (a < -12868) begin
      a += 25736;
      flip = 1'b1;
    end
    z = a * 8;
    cx = 39797;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_sh(cy, i);
      dy = floor_sh(cx, i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= atans[i];
      end else begin
        cx += dx; cy -= dy; z += atans[i];
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    sx = longint'(r.vx) * longint'({1'b0, r.sc});
    sy = longint'(r.vy) * longint'({1'b0, r.sc});
    o.x = 21'(round_place(sx * cx - sy * cy, r.ox, sat));
    o.y = 21'(round_place(sx * cy + sy * cx, r.oy, sat));
    o.sat = sat;
    return o;
  endfunction

  always @(posedge clk) begin
    vtx_res_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d", out_x, out_y);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d s=%0d got x=%0d y=%0d s=%0d",
                     e.x, e.y, e.sat, out_x, out_y, out_saturated);
        end
      end
    end
  end

  task automatic send_request(vtx_req_t r, bit known, vtx_res_t kres);
    start <= 1'b1;
    in_vertex_x <= r.vx;
    in_vertex_y <= r.vy;
    in_scale_factor <= r.sc;
    in_angle <= r.ang;
    in_offset_x <= r.ox;
    in_offset_y <= r.oy;
    do @(posedge clk); while (busy);
    expected_q.insert(expected_q.size(), known ? kres : transform_vertex(r));
  endtask

  task automatic gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic vtx_req_t rand_req();
    vtx_req_t r;
    r.vx = 16'($urandom);
    r.vy = 16'($urandom);
    r.sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    case ($urandom_range(0, 5))
      0: r.ang = 16'($urandom);
      1: r.ang = ($urandom_range(0, 1)) ? 16'sd25736 : -16'sd25736;
      default: r.ang = 16'($urandom_range(0, 51472)) - 16'sd25736;
    endcase
    r.ox = ($urandom_range(0, 3) == 0) ? 21'($urandom)
                                       : 21'($urandom_range(0, 65535)) - 21'sd32768;
    r.oy = ($urandom_range(0, 3) == 0) ? 21'($urandom)
                                       : 21'($urandom_range(0, 65535)) - 21'sd32768;
    return r;
  endfunction

  vtx_row_t table_rows[] = '{
    '{'{16'sd0, 16'sd0, 16'd0, 16'sd0, 21'sd0, 21'sd0}, 1, '{21'sd0, 21'sd0, 1'b0}},
    '{'{16'sd256, -16'sd256, 16'd0, 16'sd1000, 21'sd1048575, -21'sd1048576}, 1,
      '{21'sd1048575, -21'sd1048576, 1'b0}},
    '{'{16'sd256, 16'sd0, 16'd256, 16'sd0, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd256, 16'sd256, 16'd256, 16'sd12868, 21'sd100, -21'sd100}, 0, '{0, 0, 0}},
    '{'{16'sd256, 16'sd256, 16'd256, -16'sd12868, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd256, 16'sd256, 16'd256, 16'sd12869, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd256, 16'sd256, 16'd256, -16'sd12869, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd256, -16'sd512, 16'd256, 16'sd25736, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd256, -16'sd512, 16'd256, -16'sd25736, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd300, 16'sd77, 16'd700, 16'sd32767, 21'sd5, 21'sd9}, 0, '{0, 0, 0}},
    '{'{16'sd300, 16'sd77, 16'd700, -16'sd32768, 21'sd5, 21'sd9}, 0, '{0, 0, 0}},
    '{'{16'sd32767, 16'sd32767, 16'd65535, 16'sd0, 21'sd1048575, 21'sd1048575}, 1,
      '{21'sd1048575, 21'sd1048575, 1'b1}},
    '{'{-16'sd32768, -16'sd32768, 16'd65535, 16'sd0, -21'sd1048576, -21'sd1048576}, 1,
      '{-21'sd1048576, -21'sd1048576, 1'b1}},
    '{'{-16'sd32768, 16'sd32767, 16'd65535, 16'sd6434, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd32767, -16'sd32768, 16'd65535, -16'sd19302, -21'sd1, 21'sd1}, 0, '{0, 0, 0}},
    '{'{16'sd128, 16'sd0, 16'd1, 16'sd0, 21'sd0, 21'sd0}, 0, '{0, 0, 0}},
    '{'{16'sd32767, 16'sd0, 16'd256, 16'sd0, 21'sd1048575, 21'sd0}, 0, '{0, 0, 0}}
  };

  initial begin
    int sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      send_request(table_rows[i].req, table_rows[i].known, table_rows[i].res);
      if ($urandom_range(0, 2) == 0) gap();
    end
    sent = 0;
    while (sent < 1350) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        send_request(rand_req(), 0, '{0, 0, 0});
        sent++;
      end
      if ($urandom_range(0, 3) != 0) gap();
    end
    start <= 1'b0;
    for (int w = 0; w < 2000 && expected_q.size() != 0; w++) @(posedge clk);
    repeat (25) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
